// ----- hw/rtl/swa_pkg.sv -----
package swa_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Window-length register
    localparam int          WIN_LEN_W     = 7;
    localparam logic [6:0]  WIN_LEN_RESET = 7'd8;

    // Divider status, divider -> sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } swa_div_status_t;

endpackage

// ----- hw/rtl/swa_div.sv -----
// Restoring divider, one quotient bit per cycle.
module swa_div
    import swa_pkg::*;
#(
    parameter int NUM_W = 22,
    parameter int DEN_W = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_W-1:0]     dividend,
    input  logic [DEN_W-1:0]     divisor,
    output logic [NUM_W-1:0]     quotient,
    output swa_div_status_t      status
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W+1:0] diff;
    logic             fits;

    // trial subtract of the shifted remainder
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign fits      = ~diff[DEN_W+1];

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- hw/rtl/sliding_window_average_unit.sv -----
// Sliding-window average: each accepted sample item yields one average item,
// the running sum of the last window_length samples (fewer while the window
// fills) divided by the number held, truncated toward zero. Samples sit in a
// MAX_WINDOW-deep ring memory beside an exact running sum, a write slot and a
// fill count. Writing window_length (0 acts as 1, values above MAX_WINDOW act
// as MAX_WINDOW) restarts the filter; write it only while the block is idle.
// Each item passes through the sequencer states in order: ST_UPDATE updates the
// sum from the ring read, ST_START loads the divider, ST_DIV waits on the
// bit-serial divider, and ST_OUT hands the result to the output register
// before the return to ST_IDLE, which takes the next item. sample_ready is
// low outside ST_IDLE, and stays low longer while the previous average still
// waits unaccepted; a finished average waits in the output register while
// the next sample is taken.
module sliding_window_average_unit
    import swa_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // window-length register
    input  logic                          window_length_we,
    input  logic [WIN_LEN_W-1:0]          window_length,
    // sample items in
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    // average items out
    output logic                          average_valid,
    input  logic                          average_ready,
    output logic signed [SAMPLE_BITS-1:0] average
);

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    // sum of MAX_WINDOW samples fits here exactly
    localparam int TOT_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [WIN_LEN_W-1:0]          win_len_reg;
    logic [SLOT_W-1:0]             slot_reg, slot_next;
    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic signed [TOT_W-1:0]       total_reg, total_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic                          neg_reg;
    logic                          avg_valid_reg, avg_valid_next;
    logic signed [SAMPLE_BITS-1:0] avg_reg;

    // ring memory
    logic [SAMPLE_BITS-1:0]        ring [MAX_WINDOW];

    logic [CNT_W-1:0]              eff_win;
    logic [CNT_W-1:0]              slot_inc;
    logic                          filling;
    logic                          accept;
    logic                          div_start;
    logic [TOT_W-1:0]              total_mag;
    logic [TOT_W-1:0]              quotient;
    logic [TOT_W-1:0]              avg_wide;
    swa_div_status_t               div_status;

    assign accept       = sample_valid && sample_ready;
    assign sample_ready = (state_reg == ST_IDLE);
    assign div_start    = (state_reg == ST_START);

    // clamp the window into 1..MAX_WINDOW
    always_comb
    begin
        if (win_len_reg == '0)
        begin
            eff_win = CNT_W'(1);
        end
        else if (32'(win_len_reg) > 32'(MAX_WINDOW))
        begin
            eff_win = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            eff_win = CNT_W'(win_len_reg);
        end
    end

    assign filling  = (fill_reg < eff_win);
    assign slot_inc = CNT_W'(slot_reg) + CNT_W'(1);

    // magnitude of the sum goes to the unsigned divider
    assign total_mag = total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);
    assign avg_wide  = neg_reg ? (~quotient + TOT_W'(1)) : quotient;

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        avg_valid_next = avg_valid_reg;
        if (avg_valid_reg && average_ready)
        begin
            avg_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // oldest sample leaves only once the window is full
                if (filling)
                begin
                    total_next = total_reg + TOT_W'(sample_reg);
                    fill_next  = fill_reg + CNT_W'(1);
                end
                else
                begin
                    total_next = total_reg + TOT_W'(sample_reg) - TOT_W'(old_reg);
                end
                slot_next  = (slot_inc == eff_win) ? '0 : SLOT_W'(slot_inc);
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait for the output register to be free
                if (!avg_valid_reg || average_ready)
                begin
                    avg_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (window_length_we)
        begin
            slot_next  = '0;
            fill_next  = '0;
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_len_reg   <= WIN_LEN_RESET;
            slot_reg      <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            avg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            avg_valid_reg <= avg_valid_next;
            if (window_length_we)
            begin
                win_len_reg <= window_length;
            end
        end
    end

    // payload registers and ring memory
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            old_reg    <= ring[slot_reg];
        end
        if (state_reg == ST_UPDATE)
        begin
            ring[slot_reg] <= sample_reg;
        end
        if (div_start)
        begin
            neg_reg <= total_reg[TOT_W-1];
        end
        if ((state_reg == ST_OUT) && (!avg_valid_reg || average_ready))
        begin
            avg_reg <= avg_wide[SAMPLE_BITS-1:0];
        end
    end

    swa_div #(
        .NUM_W (TOT_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_mag),
        .divisor  (fill_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    assign average_valid = avg_valid_reg;
    assign average       = avg_reg;

endmodule

// ----- hw/rtl/swa_checker.sv -----
// Port-level checks for the sliding-window average unit.
module swa_checker
    import swa_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          sample_valid,
    input logic                          sample_ready,
    input logic signed [SAMPLE_BITS-1:0] sample,
    input logic                          average_valid,
    input logic                          average_ready,
    input logic signed [SAMPLE_BITS-1:0] average
);

    // a stalled average item holds
    a_avg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        average_valid && !average_ready |=> average_valid && $stable(average))
        else $error("average changed while stalled");

    // one item at a time: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("ready high right after accept");

    // a new average only appears at the end of an item's work
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(average_valid) |-> $past(!sample_ready))
        else $error("average appeared while idle");

    // no new average while the accepted sample is in ST_UPDATE or ST_START
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !$rose(average_valid) ##1 !$rose(average_valid))
        else $error("average too soon after accept");

endmodule

bind sliding_window_average_unit swa_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample        (sample),
    .average_valid (average_valid),
    .average_ready (average_ready),
    .average       (average)
);
